/* hw/rtl/imuac_pkg.sv */
// Shared types and constants of the IMU ADC smoothing and offset calibration block.
package imuac_pkg;

	localparam int CHANNELS        = 6;
	localparam int SAMPLE_W        = 10;
	localparam int OFFSET_W        = SAMPLE_W + 1;
	localparam int VALUE_W         = 12;
	localparam int VALUE_MAX       = 2047;
	localparam int COUNT_W         = 8;
	localparam int GRAVITY_CHANNEL = 1;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 10;
	localparam int MASK_W          = CHANNELS;
	localparam int GRAVITY_W       = 10;

	// Filter arithmetic: sum = filtered + 9 * previous, divided by 10 through a
	// reciprocal that is exact for every sum below 2**SUM_W.
	localparam int FILTER_WEIGHT = 9;
	localparam int SUM_W         = SAMPLE_W + 4;
	localparam int DIV_SHIFT     = SUM_W + 3;
	localparam int PROD_W        = 2 * SUM_W;
	localparam logic [SUM_W-1:0] RECIP_10 = SUM_W'(((2 ** DIV_SHIFT) + 9) / 10);

	localparam logic [CFG_INDEX_W-1:0] REG_SIGN_MASK = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE    = 2'd2;

	localparam logic [MASK_W-1:0]    SIGN_MASK_RST = MASK_W'(18);
	localparam logic [GRAVITY_W-1:0] GRAVITY_RST   = '0;
	localparam logic [COUNT_W-1:0]   SETTLE_RST    = COUNT_W'(100);

	typedef logic [SAMPLE_W-1:0]        sample_t;
	typedef logic [OFFSET_W-1:0]        offset_t;
	typedef logic signed [VALUE_W-1:0]  value_t;
	typedef logic [COUNT_W-1:0]         count_t;

	typedef struct packed {
		sample_t sample_0;
		sample_t sample_1;
		sample_t sample_2;
		sample_t sample_3;
		sample_t sample_4;
		sample_t sample_5;
	} in_word_t;

	typedef struct packed {
		value_t value_0;
		value_t value_1;
		value_t value_2;
		value_t value_3;
		value_t value_4;
		value_t value_5;
		count_t sequence_count;
		logic   calibrated;
	} out_word_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  value;
	} cfg_word_t;

	typedef struct packed {
		logic                 accept;
		logic                 calibrate;
		logic [GRAVITY_W-1:0] bias;
	} lane_ctl_t;

	typedef struct packed {
		logic   valid;
		count_t count;
		logic   calibrated;
	} stage_info_t;

endpackage

/* hw/rtl/imuac_stream_if.sv */
// Valid/ready channel interface carrying one word of a given payload type.
interface imuac_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/imuac_lane.sv */
// One channel lane: smoothing filter, offset latch and corrected value.
module imuac_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  imuac_pkg::lane_ctl_t ctl,
	input  imuac_pkg::sample_t  sample,
	input  logic                negate,
	output imuac_pkg::value_t   value
);
	import imuac_pkg::*;

	localparam logic signed [VALUE_W:0] CLAMP_HI = (VALUE_W + 1)'(VALUE_MAX);
	localparam logic signed [VALUE_W:0] CLAMP_LO = -CLAMP_HI;

	sample_t            filt_q;
	sample_t            prev_q;
	offset_t            off_q;
	sample_t            filt_s1;
	offset_t            off_s1;
	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;
	sample_t            filt_new;
	offset_t            off_new;
	logic signed [VALUE_W:0] diff;
	logic signed [VALUE_W:0] corr;

	always_comb begin
		sum      = SUM_W'(filt_q) + SUM_W'(prev_q) * SUM_W'(FILTER_WEIGHT);
		prod     = PROD_W'(sum) * PROD_W'(RECIP_10);
		filt_new = prod[DIV_SHIFT +: SAMPLE_W];
		off_new  = ctl.calibrate ? (OFFSET_W'(filt_new) + OFFSET_W'(ctl.bias)) : off_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			prev_q <= '0;
			off_q  <= '0;
		end else if (ctl.accept) begin
			filt_q <= filt_new;
			prev_q <= sample;
			off_q  <= off_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			filt_s1 <= filt_new;
			off_s1  <= off_new;
		end
	end

	always_comb begin
		diff = $signed((VALUE_W + 1)'(filt_s1)) - $signed((VALUE_W + 1)'(off_s1));
		corr = negate ? -diff : diff;
		priority if (corr > CLAMP_HI) begin
			value = CLAMP_HI[VALUE_W-1:0];
		end else if (corr < CLAMP_LO) begin
			value = CLAMP_LO[VALUE_W-1:0];
		end else begin
			value = corr[VALUE_W-1:0];
		end
	end

endmodule

/* hw/rtl/imuac_merge.sv */
// Output stage that gathers the lane values into one result word and holds it.
module imuac_merge (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  imuac_pkg::value_t [imuac_pkg::CHANNELS-1:0]   lane_value,
	input  imuac_pkg::stage_info_t                        info,
	output logic                                          advance,
	imuac_stream_if.source                                result_ch
);
	import imuac_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	assign advance = !valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= info.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && info.valid) begin
			word_q.value_0        <= lane_value[0];
			word_q.value_1        <= lane_value[1];
			word_q.value_2        <= lane_value[2];
			word_q.value_3        <= lane_value[3];
			word_q.value_4        <= lane_value[4];
			word_q.value_5        <= lane_value[5];
			word_q.sequence_count <= info.count;
			word_q.calibrated     <= info.calibrated;
		end
	end

	assign result_ch.valid = valid_q;
	assign result_ch.data  = word_q;

endmodule

/* hw/rtl/imu_adc_smoothing_and_offset_calibration.sv */
// Top level of the IMU ADC smoothing and offset calibration block.
//
// Usage: each word on sample_ch carries one conversion sequence of six raw
// 10-bit samples. Each channel has its own lane that updates the smoothed
// value from the previous raw sample, and an output stage packs the six
// corrected values with the sequence count and the calibrated flag into one
// word on result_ch. The cfg channel writes sign_mask (index 0),
// gravity_offset (index 1) and settle_count (index 2); other indexes are
// dropped, and cfg is always ready. Write it only while the block is idle.
// An accepted sample word is registered in the lane stage and then in the
// output stage, whose register drives result_ch.
// The block takes one word per cycle unless result_ch stalls; the filter
// update in each lane, an add and a reciprocal multiply, bounds that rate.
// When result_ch stalls, the held result stays and one more word waits in
// the lane stage; after that sample_ch.ready drops until result_ch moves.
// Reset clears the filter state and offset of each lane, the counter and
// the flag, and loads the registers with their default values.
module imu_adc_smoothing_and_offset_calibration (
	input  logic          clk,
	input  logic          arst_n,
	imuac_stream_if.sink  sample_ch,
	imuac_stream_if.source result_ch,
	imuac_stream_if.sink  cfg
);
	import imuac_pkg::*;

	logic [MASK_W-1:0]    sign_q;
	logic [GRAVITY_W-1:0] grav_q;
	count_t               settle_q;
	count_t               count_q;
	logic                 cal_q;
	count_t               count_next;
	logic                 accept;
	logic                 calibrate;
	logic                 advance;
	logic                 valid_s1;
	count_t               count_s1;
	logic                 cal_s1;
	stage_info_t          info;
	lane_ctl_t [CHANNELS-1:0] lane_ctl;
	sample_t [CHANNELS-1:0]   samples;
	value_t [CHANNELS-1:0]    lane_value;

	assign cfg.ready       = 1'b1;
	assign sample_ch.ready = !valid_s1 || advance;
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign count_next      = count_q + COUNT_W'(1);
	assign calibrate       = accept && !cal_q && (count_next == settle_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q   <= SIGN_MASK_RST;
			grav_q   <= GRAVITY_RST;
			settle_q <= SETTLE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_SIGN_MASK: sign_q   <= cfg.data.value[MASK_W-1:0];
				REG_GRAVITY:   grav_q   <= cfg.data.value[GRAVITY_W-1:0];
				REG_SETTLE:    settle_q <= cfg.data.value[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cal_q   <= 1'b0;
		end else if (accept) begin
			count_q <= count_next;
			cal_q   <= cal_q || calibrate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1 <= count_next;
			cal_s1   <= cal_q || calibrate;
		end
	end

	always_comb begin
		samples[0] = sample_ch.data.sample_0;
		samples[1] = sample_ch.data.sample_1;
		samples[2] = sample_ch.data.sample_2;
		samples[3] = sample_ch.data.sample_3;
		samples[4] = sample_ch.data.sample_4;
		samples[5] = sample_ch.data.sample_5;
		for (int c = 0; c < CHANNELS; c++) begin
			lane_ctl[c].accept    = accept;
			lane_ctl[c].calibrate = calibrate;
			lane_ctl[c].bias      = (c == GRAVITY_CHANNEL) ? grav_q : '0;
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		imuac_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl[g]),
			.sample (samples[g]),
			.negate (sign_q[g]),
			.value  (lane_value[g])
		);
	end

	assign info = '{valid: valid_s1, count: count_s1, calibrated: cal_s1};

	imuac_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_value (lane_value),
		.info       (info),
		.advance    (advance),
		.result_ch  (result_ch)
	);

	a_cal_at_settle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cal_q) |-> count_q == $past(settle_q))
		else $error("Calibration latched away from the settle count.");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("Sequence counter did not advance on an accepted word.");

	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q |=> cal_q)
		else $error("Calibrated flag cleared without reset.");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(count_s1))
		else $error("Lane stage word lost while the output stage was full.");

endmodule
